### design/sha256_pkg.sv
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_done;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // Word source for the schedule load.
   typedef enum logic [1:0] {
      SRC_BUFFER,
      SRC_PAD_ZERO,
      SRC_LENGTH
   } load_src_type;

   typedef struct packed {
      logic         write_byte;
      logic         load_word;
      load_src_type load_src;
      logic [3:0]   load_index;
      logic         init_vars;
      logic         do_round;
      logic [5:0]   round_index;
      logic         update_chain;
      logic         restart;
      logic         pad_marker;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill_count;
      logic       fill_wrap;
   } dp_status_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned LENGTH_LIMIT = 56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

### design/sha256_datapath.sv
module sha256_datapath
   import sha256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   input  logic [7:0]      in_byte,
   input  logic [2:0]      out_select,
   output dp_status_type   status,
   output logic [31:0]     digest_word
);

   logic [31:0] block_ff [16];
   logic [31:0] window_ff [16];
   logic [31:0] vars_ff [8];
   logic [31:0] chain_ff [8];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] bytes_ff, bytes_in;
   logic [31:0] load_word;
   logic [63:0] bit_len;
   logic [31:0] w_cur, w15, w2, s0, s1, t1, t2;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic        wr_en;

   // Byte store: message bytes, or the pad marker at the fill position.
   always_comb begin
      wr_en   = cmd.write_byte || cmd.pad_marker;
      wr_addr = fill_ff;
      wr_data = cmd.pad_marker ? PAD_BYTE : in_byte;
   end

   // Block held as 16 big-endian words; byte 0 of a word is its top lane.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_ff[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
      end
   end

   assign bit_len = {bytes_ff, 3'b000};

   // Word k of the block: bytes up to and including the fill mark (all after a wrap), zero above it.
   always_comb begin
      logic [7:0]  byte_sel [4];
      logic [5:0]  pos;
      logic [31:0] word_raw;
      word_raw = block_ff[cmd.load_index];
      for (int i = 0; i < 4; i++) begin
         pos = {cmd.load_index, i[1:0]};
         byte_sel[i] = (pos <= fill_ff || status.fill_wrap) ? word_raw[8*(3-i) +: 8] : 8'h00;
      end
      unique case (cmd.load_src)
         SRC_BUFFER:   load_word = {byte_sel[0], byte_sel[1], byte_sel[2], byte_sel[3]};
         SRC_PAD_ZERO: load_word = '0;
         SRC_LENGTH:   load_word = cmd.load_index[0] ? bit_len[31:0] : bit_len[63:32];
         default:      load_word = '0;
      endcase
   end

   always_comb begin
      a = vars_ff[0]; b = vars_ff[1]; c = vars_ff[2]; d = vars_ff[3];
      e = vars_ff[4]; f = vars_ff[5]; g = vars_ff[6]; h = vars_ff[7];
      w15 = window_ff[1];
      w2  = window_ff[14];
      s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      w_cur = (cmd.round_index < 6'd16) ? window_ff[0]
            : window_ff[0] + s0 + window_ff[9] + s1;
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[cmd.round_index] + w_cur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
   end

   // Window shifts by one word per load or round; slot 0 is the current word.
   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         for (int i = 0; i < 15; i++) window_ff[i] <= window_ff[i + 1];
         window_ff[15] <= load_word;
      end else if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) window_ff[i] <= window_ff[i + 1];
         window_ff[15] <= w_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_vars) begin
         for (int i = 0; i < 8; i++) vars_ff[i] <= chain_ff[i];
      end else if (cmd.do_round) begin
         vars_ff[7] <= g; vars_ff[6] <= f; vars_ff[5] <= e; vars_ff[4] <= d + t1;
         vars_ff[3] <= c; vars_ff[2] <= b; vars_ff[1] <= a; vars_ff[0] <= t1 + t2;
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      if (cmd.restart) begin
         fill_in  = '0;
         bytes_in = '0;
      end else if (cmd.write_byte) begin
         fill_in  = fill_ff + 6'd1;
         bytes_in = bytes_ff + 61'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         bytes_ff <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= INIT_HASH[i];
      end else begin
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
         if (cmd.restart) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= INIT_HASH[i];
         end else if (cmd.update_chain) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + vars_ff[i];
         end
      end
   end

   // fill_wrap: a full block has just wrapped fill to zero, all bytes valid.
   logic wrap_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
      end else if (cmd.write_byte) begin
         wrap_ff <= (fill_ff == 6'd63);
      end else if (cmd.pad_marker || cmd.restart) begin
         wrap_ff <= 1'b0;
      end
   end

   assign status.fill_count = fill_ff;
   assign status.fill_wrap  = wrap_ff;
   assign digest_word       = chain_ff[out_select];

endmodule

### design/sha256_control.sv
module sha256_control
   import sha256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [2:0]      word_index,
   input  dp_status_type   status,
   output dp_cmd_type      cmd
);

   state_type   state_ff, state_in;
   logic [5:0]  count_ff, count_in;
   logic        final_ff, final_in;   // compressing a finishing block
   logic        extra_ff, extra_in;   // length goes in a second block
   logic        pad_ff, pad_in;       // pad marker still to be written
   logic        end_ff, end_in;       // message end pending after a byte block
   logic [2:0]  word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         final_ff <= 1'b0;
         extra_ff <= 1'b0;
         pad_ff   <= 1'b0;
         end_ff   <= 1'b0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         final_ff <= final_in;
         extra_ff <= extra_in;
         pad_ff   <= pad_in;
         end_ff   <= end_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      logic accept;
      state_in  = state_ff;
      count_in  = count_ff;
      final_in  = final_ff;
      extra_in  = extra_ff;
      pad_in    = pad_ff;
      end_in    = end_ff;
      word_in   = word_ff;
      cmd       = '0;
      cmd.load_src    = SRC_BUFFER;
      cmd.load_index  = count_ff[3:0];
      cmd.round_index = count_ff;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      accept    = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (pad_ff) begin
               req_ready      = 1'b0;
               accept         = 1'b0;
               cmd.pad_marker = 1'b1;
               pad_in         = 1'b0;
               extra_in       = (status.fill_count >= 6'(LENGTH_LIMIT));
               final_in       = 1'b1;
               count_in       = '0;
               state_in       = ST_LOAD;
            end else if (accept) begin
               cmd.write_byte = req_payload.byte_present;
               if (req_payload.byte_present && status.fill_count == 6'd63) begin
                  end_in   = req_payload.message_end;
                  count_in = '0;
                  state_in = ST_LOAD;
               end else if (req_payload.message_end) begin
                  pad_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_word = 1'b1;
            if (final_ff && !extra_ff && count_ff[3:0] >= 4'd14) begin
               cmd.load_src   = SRC_LENGTH;
               cmd.load_index = {3'b000, count_ff[0]};
            end else if (final_ff && pad_ff) begin
               cmd.load_src = SRC_PAD_ZERO;
            end
            if (count_ff == 6'd15) begin
               cmd.init_vars = 1'b1;
               count_in      = '0;
               state_in      = ST_ROUND;
            end else begin
               count_in = count_ff + 6'd1;
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            count_in     = count_ff + 6'd1;
            if (count_ff == 6'd63) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update_chain = 1'b1;
            count_in         = '0;
            if (end_ff) begin
               // byte completed a block and ended the message: pad next
               end_in   = 1'b0;
               pad_in   = 1'b1;
               state_in = ST_IDLE;
            end else if (final_ff && extra_ff) begin
               // second finishing block: zeros and length only
               extra_in = 1'b0;
               pad_in   = 1'b1;
               state_in = ST_LOAD;
            end else if (final_ff) begin
               pad_in   = 1'b0;
               word_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  final_in    = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign word_index = word_ff;

endmodule

### design/sha256_message_hasher.sv
// SHA-256 hasher taking a message one byte per transaction. Bytes are
// buffered into a 64-byte block store; a full block is loaded into the
// schedule window and compressed at one round per cycle, followed by the
// chaining update. A transaction with message_end set pads the message
// (one or two final blocks, two when 56 or more bytes are buffered) and
// then presents the 256-bit digest as eight rsp_ transactions, word 0
// first, digest_done on word 7. The block then restarts from the initial
// hash values. No request is taken while a block compresses or the digest
// is being delivered.
module sha256_message_hasher
   import sha256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    word_index;
   logic [31:0]   digest_word;

   sha256_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .word_index  (word_index),
      .status      (status),
      .cmd         (cmd)
   );

   sha256_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_payload.data_byte),
      .out_select  (word_index),
      .status      (status),
      .digest_word (digest_word)
   );

   assign rsp_payload.digest_word = digest_word;
   assign rsp_payload.word_index  = word_index;
   assign rsp_payload.digest_done = (word_index == 3'd7);

   // Hold off requests while a result is pending.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request taken during digest delivery");

   // Drop valid only after the last word is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_ready && word_index == 3'd7)) |=> rsp_valid)
      else $error("digest delivery ended early");

   // Advance the word index by one per delivered word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && word_index != 3'd7) |=>
      word_index == $past(word_index) + 3'd1)
      else $error("word index skipped");

endmodule
